// ===== sv/cta_pkg.sv =====
package cta_pkg;

  // request and result payloads
  typedef struct packed {
    logic               command;
    logic [2:0]         unit;
    logic signed [15:0] amount;
  } cta_req_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic [2:0]         season;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               year_overflow;
  } cta_rsp_t;

  // carry width between cells, and the working width inside a cell
  localparam int DELTA_W     = 17;
  localparam int VALUE_W     = DELTA_W + 1;
  localparam int RECIP_SHIFT = 24;

  // carry token handed from one cell to the next
  typedef struct packed {
    logic                      valid;
    logic                      go;
    logic signed [DELTA_W-1:0] delta;
  } cta_tok_t;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SET = 1'b1;

  localparam logic [2:0] UNIT_SECOND = 3'd0;
  localparam logic [2:0] UNIT_MINUTE = 3'd1;
  localparam logic [2:0] UNIT_HOUR   = 3'd2;
  localparam logic [2:0] UNIT_DAY    = 3'd3;
  localparam logic [2:0] UNIT_MONTH  = 3'd4;
  localparam logic [2:0] UNIT_SEASON = 3'd5;
  localparam logic [2:0] UNIT_YEAR   = 3'd6;

  localparam int SECS_PER_MIN    = 60;
  localparam int MINS_PER_HOUR   = 60;
  localparam int HOURS_IN_DAY    = 24;
  localparam int DAYS_IN_MONTH   = 30;
  localparam int MONTHS_IN_YEAR  = 12;
  localparam int SEASONS_IN_YEAR = 4;

  function automatic logic [2:0] season_of_month(input logic [3:0] m);
    logic [2:0] s;
    case (m) inside
      [4'd1:4'd3]:   s = 3'd1;
      [4'd4:4'd6]:   s = 3'd2;
      [4'd7:4'd9]:   s = 3'd3;
      [4'd10:4'd12]: s = 3'd4;
      default:       s = 3'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/cta_digit_cell.sv =====
module cta_digit_cell #(
  parameter int BASE    = 60,
  parameter int LO      = 0,
  parameter int RST_VAL = 0,
  localparam int CW     = $clog2(BASE + LO)
) (
  input  logic               clk,
  input  logic               rst,
  input  cta_pkg::cta_tok_t  tok_in,
  input  logic               load,
  input  logic [CW-1:0]      load_val,
  output cta_pkg::cta_tok_t  tok_out,
  output logic [CW-1:0]      count
);

  localparam int VW = cta_pkg::VALUE_W;
  localparam int S  = cta_pkg::RECIP_SHIFT;
  localparam logic [S-1:0] RECIP = S'((64'd1 << S) / BASE);

  // stage 1: offset value folded to a magnitude
  logic signed [VW-1:0] v;
  logic [VW-1:0]        m0;
  logic                 s1_valid, s1_go, s1_neg;
  logic [VW-1:0]        s1_m;

  // stage 2: quotient estimate by reciprocal
  logic [VW+S-1:0] prod;
  logic            s2_valid, s2_go, s2_neg;
  logic [VW-1:0]   s2_m, s2_qe;

  // stage 3: correction, new count and carry
  logic [VW-1:0]        qb, rem, rem2, qm, r;
  logic                 corr;
  logic signed [VW-1:0] q;
  logic [CW-1:0]        count_next;

  always_comb begin
    v  = VW'($signed({1'b0, count})) - VW'(LO) + VW'(tok_in.delta);
    m0 = v[VW-1] ? (VW'(BASE - 1) - v) : v;
  end

  assign prod = (VW+S)'(s1_m) * (VW+S)'(RECIP);

  always_comb begin
    qb         = VW'(s2_qe * VW'(BASE));
    rem        = s2_m - qb;
    corr       = (rem >= VW'(BASE));
    rem2       = corr ? (rem - VW'(BASE)) : rem;
    qm         = s2_qe + VW'(corr);
    r          = s2_neg ? (VW'(BASE - 1) - rem2) : rem2;
    q          = s2_neg ? -$signed(qm) : $signed(qm);
    count_next = CW'(r + VW'(LO));
  end

  always_ff @(posedge clk) begin
    s1_m  <= m0;
    s2_m  <= s1_m;
    s2_qe <= prod[VW+S-1:S];
    s1_neg <= v[VW-1];
    s2_neg <= s1_neg;
    tok_out.delta <= q[cta_pkg::DELTA_W-1:0];
    if (rst) begin
      s1_valid      <= 1'b0;
      s1_go         <= 1'b0;
      s2_valid      <= 1'b0;
      s2_go         <= 1'b0;
      tok_out.valid <= 1'b0;
      tok_out.go    <= 1'b0;
      count         <= CW'(RST_VAL);
    end else begin
      s1_valid      <= tok_in.valid;
      s1_go         <= tok_in.valid & tok_in.go;
      s2_valid      <= s1_valid;
      s2_go         <= s1_go;
      tok_out.valid <= s2_valid;
      tok_out.go    <= s2_go && (q != '0);
      if (load) begin
        count <= load_val;
      end else if (s2_go) begin
        count <= count_next;
      end
    end
  end

endmodule

// ===== sv/cta_year_cell.sv =====
module cta_year_cell #(
  parameter int YEAR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cta_pkg::cta_tok_t     tok_in,
  input  logic                  load,
  input  logic [YEAR_BITS-1:0]  load_val,
  output logic [YEAR_BITS-1:0]  year,
  output logic                  done,
  output logic                  ovf
);

  localparam int YSW = ((YEAR_BITS > cta_pkg::DELTA_W) ? YEAR_BITS : cta_pkg::DELTA_W) + 1;

  logic signed [YSW-1:0]       sum, wrapped;
  logic signed [YEAR_BITS-1:0] low;

  always_comb begin
    sum     = YSW'($signed(year)) + YSW'(tok_in.delta);
    low     = sum[YEAR_BITS-1:0];
    wrapped = YSW'(low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year <= '0;
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= tok_in.valid;
      if (tok_in.valid) begin
        ovf <= tok_in.go && (sum != wrapped);
      end
      if (load) begin
        year <= load_val;
      end else if (tok_in.valid && tok_in.go) begin
        year <= sum[YEAR_BITS-1:0];
      end
    end
  end

endmodule

// ===== sv/calendar_time_adder.sv =====
// channel   direction  payload     handshake
// request   in         cta_req_t   request_valid / request_stall
// result    out        cta_rsp_t   result_valid  / result_stall
//
// one request at a time; a set, or an add to an unused unit code, goes straight
// to the final state; any other add sends its token from the addressed cell on
// to the year cell, through each digit cell up to the month or, for a season
// add, through the season cell; the result follows once the year cell is done
// each digit cell works in registered stages: offset, reciprocal multiply, correction
// rst (synchronous) restores 06:00:00, day 1, month 1, season 1, year 0
// a waiting result does not block acceptance of the next request; a stalled
// result holds the block in its final state until the result is taken
module calendar_time_adder #(
  parameter int YEAR_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  cta_pkg::cta_req_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output cta_pkg::cta_rsp_t result
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  logic accept, start_add, set_now;
  logic ovf_flag;

  // carry tokens along the chain
  cta_pkg::cta_tok_t inj;
  cta_pkg::cta_tok_t sec_in, min_in, hour_in, day_in, month_in, season_in, year_in;
  cta_pkg::cta_tok_t sec_out, min_out, hour_out, day_out, month_out, season_out;

  // counts held by the cells
  logic [5:0]           sec_cnt, min_cnt;
  logic [4:0]           hour_cnt, day_cnt;
  logic [3:0]           month_cnt;
  logic [2:0]           season_cnt;
  logic [YEAR_BITS-1:0] year_cnt;
  logic [31:0]          year_ext;
  logic signed [31:0]   amount_ext;

  logic       year_done, year_ovf;
  logic       season_load;
  logic [2:0] season_val;
  logic       month_reached;

  // clamped set values
  logic [5:0] c_sec, c_min, c_hour, c_day, c_month, c_season;

  function automatic logic [5:0] clamp6(input logic signed [15:0] a, input int lo,
                                        input int hi);
    logic [5:0] c;
    if (int'(a) < lo) begin
      c = 6'(lo);
    end else if (int'(a) > hi) begin
      c = 6'(hi);
    end else begin
      c = a[5:0];
    end
    return c;
  endfunction

  assign request_stall = (state != ST_IDLE);
  assign accept        = request_valid && !request_stall;
  assign start_add     = accept && (request.command == cta_pkg::CMD_ADD);
  assign set_now       = accept && (request.command == cta_pkg::CMD_SET);

  always_comb begin
    c_sec    = clamp6(request.amount, 0, cta_pkg::SECS_PER_MIN - 1);
    c_min    = clamp6(request.amount, 0, cta_pkg::MINS_PER_HOUR - 1);
    c_hour   = clamp6(request.amount, 0, cta_pkg::HOURS_IN_DAY - 1);
    c_day    = clamp6(request.amount, 1, cta_pkg::DAYS_IN_MONTH);
    c_month  = clamp6(request.amount, 1, cta_pkg::MONTHS_IN_YEAR);
    c_season = clamp6(request.amount, 1, cta_pkg::SEASONS_IN_YEAR);
  end

  // new token enters the chain at the addressed unit
  assign inj.valid = start_add;
  assign inj.go    = 1'b1;
  assign inj.delta = cta_pkg::DELTA_W'(request.amount);

  always_comb begin
    sec_in    = '0;
    min_in    = sec_out;
    hour_in   = min_out;
    day_in    = hour_out;
    month_in  = day_out;
    season_in = '0;
    year_in   = month_out.valid ? month_out : season_out;
    // only a fresh add injects; otherwise pass the neighbor's token
    if (start_add) begin
      case (request.unit)
        cta_pkg::UNIT_SECOND: sec_in    = inj;
        cta_pkg::UNIT_MINUTE: min_in    = inj;
        cta_pkg::UNIT_HOUR:   hour_in   = inj;
        cta_pkg::UNIT_DAY:    day_in    = inj;
        cta_pkg::UNIT_MONTH:  month_in  = inj;
        cta_pkg::UNIT_SEASON: season_in = inj;
        cta_pkg::UNIT_YEAR:   year_in   = inj;
        default: ;
      endcase
    end
  end

  // season follows the month whenever an add reached the month, even with
  // no carry out of it
  assign season_load = (set_now && request.unit == cta_pkg::UNIT_SEASON)
                       || (month_out.valid && month_reached);
  assign season_val  = (set_now && request.unit == cta_pkg::UNIT_SEASON)
                       ? c_season[2:0] : cta_pkg::season_of_month(month_cnt);

  assign amount_ext = 32'(request.amount);

  cta_digit_cell #(.BASE(cta_pkg::SECS_PER_MIN), .LO(0), .RST_VAL(0)) u_sec (
    .clk, .rst, .tok_in(sec_in),
    .load(set_now && request.unit == cta_pkg::UNIT_SECOND), .load_val(c_sec),
    .tok_out(sec_out), .count(sec_cnt)
  );

  cta_digit_cell #(.BASE(cta_pkg::MINS_PER_HOUR), .LO(0), .RST_VAL(0)) u_min (
    .clk, .rst, .tok_in(min_in),
    .load(set_now && request.unit == cta_pkg::UNIT_MINUTE), .load_val(c_min),
    .tok_out(min_out), .count(min_cnt)
  );

  cta_digit_cell #(.BASE(cta_pkg::HOURS_IN_DAY), .LO(0), .RST_VAL(6)) u_hour (
    .clk, .rst, .tok_in(hour_in),
    .load(set_now && request.unit == cta_pkg::UNIT_HOUR), .load_val(c_hour[4:0]),
    .tok_out(hour_out), .count(hour_cnt)
  );

  cta_digit_cell #(.BASE(cta_pkg::DAYS_IN_MONTH), .LO(1), .RST_VAL(1)) u_day (
    .clk, .rst, .tok_in(day_in),
    .load(set_now && request.unit == cta_pkg::UNIT_DAY), .load_val(c_day[4:0]),
    .tok_out(day_out), .count(day_cnt)
  );

  cta_digit_cell #(.BASE(cta_pkg::MONTHS_IN_YEAR), .LO(1), .RST_VAL(1)) u_month (
    .clk, .rst, .tok_in(month_in),
    .load(set_now && request.unit == cta_pkg::UNIT_MONTH), .load_val(c_month[3:0]),
    .tok_out(month_out), .count(month_cnt)
  );

  cta_digit_cell #(.BASE(cta_pkg::SEASONS_IN_YEAR), .LO(1), .RST_VAL(1)) u_season (
    .clk, .rst, .tok_in(season_in),
    .load(season_load), .load_val(season_val),
    .tok_out(season_out), .count(season_cnt)
  );

  cta_year_cell #(.YEAR_BITS(YEAR_BITS)) u_year (
    .clk, .rst, .tok_in(year_in),
    .load(set_now && request.unit == cta_pkg::UNIT_YEAR),
    .load_val(amount_ext[YEAR_BITS-1:0]),
    .year(year_cnt), .done(year_done), .ovf(year_ovf)
  );

  assign year_ext = 32'(year_cnt);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (start_add && request.unit <= cta_pkg::UNIT_YEAR) begin
            state_next = ST_RUN;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        if (year_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!result_valid || !result_stall)) begin
      result.year          <= year_ext[15:0];
      result.season        <= season_cnt;
      result.month         <= month_cnt;
      result.day           <= day_cnt;
      result.hour          <= hour_cnt;
      result.minute        <= min_cnt;
      result.second        <= sec_cnt;
      result.year_overflow <= ovf_flag;
    end
    if (rst) begin
      state         <= ST_IDLE;
      ovf_flag      <= 1'b0;
      result_valid  <= 1'b0;
      month_reached <= 1'b0;
    end else begin
      state <= state_next;
      // remember whether the token entering the month cell updates it
      if (month_in.valid) begin
        month_reached <= month_in.go;
      end
      if (accept) begin
        ovf_flag <= 1'b0;
      end else if (state == ST_RUN && year_done) begin
        ovf_flag <= year_ovf;
      end
      if (state == ST_FIN && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/tb_calendar_time_adder.sv =====
module tb_calendar_time_adder;
  timeunit 1ns;
  timeprecision 1ps;

  // unit code with no unit behind it
  localparam logic [2:0] UNIT_SPARE = 3'd7;

  localparam logic signed [15:0] AMT_MAX = 16'sh7fff;
  localparam logic signed [15:0] AMT_MIN = 16'sh8000;

  localparam int YEAR_W     = 16;
  localparam int YEAR_LIM   = 1 << (YEAR_W - 1);
  localparam int RANDOM_N   = 1075;
  localparam int LONG_HOLD  = 400;   // receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 40;    // longest path is an add to the second
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake at all
  localparam int PRINT_CAP  = 50;

  localparam cta_pkg::cta_rsp_t NO_TIME = '0;

  logic              clk;
  logic              rst;
  logic              request_valid;
  logic              request_stall;
  cta_pkg::cta_req_t request;
  logic              result_valid;
  logic              result_stall;
  cta_pkg::cta_rsp_t result;

  calendar_time_adder #(
    .YEAR_BITS(YEAR_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // calendar predictor: its own copy of the time, at the block's widths
  // ---------------------------------------------------------------------
  logic signed [15:0] cal_year;
  logic [2:0]         cal_season;
  logic [3:0]         cal_month;
  logic [4:0]         cal_day;
  logic [4:0]         cal_hour;
  logic [5:0]         cal_min;
  logic [5:0]         cal_sec;

  // fold cur + delta into [lo, lo+base-1]; returns the floor carry
  function automatic int wrap_digit(input int cur, input int delta, input int lo,
                                    input int base, output int nxt);
    int v;
    int q;
    int r;
    v = cur + delta - lo;
    q = v / base;
    r = v - q * base;
    if (r < 0) begin
      r += base;
      q -= 1;
    end
    nxt = r + lo;
    return q;
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // add to the year; flags a wrap out of the signed year range
  function automatic logic bump_year(input int delta);
    int v;
    v = int'(cal_year) + delta;
    cal_year = 16'(v);
    return (v < -YEAR_LIM || v > YEAR_LIM - 1);
  endfunction

  function automatic cta_pkg::cta_rsp_t calendar_step(input cta_pkg::cta_req_t r);
    cta_pkg::cta_rsp_t t;
    int                amt;
    int                d;
    int                nxt;
    logic              go;
    logic              ovf;
    amt = int'(r.amount);
    ovf = 1'b0;
    if (r.command == cta_pkg::CMD_SET) begin
      // a set clamps and never carries
      case (r.unit)
        cta_pkg::UNIT_SECOND: cal_sec    = 6'(clip(amt, 0, cta_pkg::SECS_PER_MIN - 1));
        cta_pkg::UNIT_MINUTE: cal_min    = 6'(clip(amt, 0, cta_pkg::MINS_PER_HOUR - 1));
        cta_pkg::UNIT_HOUR:   cal_hour   = 5'(clip(amt, 0, cta_pkg::HOURS_IN_DAY - 1));
        cta_pkg::UNIT_DAY:    cal_day    = 5'(clip(amt, 1, cta_pkg::DAYS_IN_MONTH));
        cta_pkg::UNIT_MONTH:  cal_month  = 4'(clip(amt, 1, cta_pkg::MONTHS_IN_YEAR));
        cta_pkg::UNIT_SEASON: cal_season = 3'(clip(amt, 1, cta_pkg::SEASONS_IN_YEAR));
        cta_pkg::UNIT_YEAR:   cal_year   = r.amount;
        default: ;
      endcase
    end else if (r.unit == cta_pkg::UNIT_SEASON) begin
      // season carries straight into the year, month untouched
      d = wrap_digit(int'(cal_season), amt, 1, cta_pkg::SEASONS_IN_YEAR, nxt);
      cal_season = 3'(nxt);
      ovf = bump_year(d);
    end else if (r.unit == cta_pkg::UNIT_YEAR) begin
      ovf = bump_year(amt);
    end else if (r.unit <= cta_pkg::UNIT_MONTH) begin
      d  = amt;
      go = 1'b1;
      if (go && r.unit <= cta_pkg::UNIT_SECOND) begin
        d = wrap_digit(int'(cal_sec), d, 0, cta_pkg::SECS_PER_MIN, nxt);
        cal_sec = 6'(nxt);
        go = (d != 0);
      end
      if (go && r.unit <= cta_pkg::UNIT_MINUTE) begin
        d = wrap_digit(int'(cal_min), d, 0, cta_pkg::MINS_PER_HOUR, nxt);
        cal_min = 6'(nxt);
        go = (d != 0);
      end
      if (go && r.unit <= cta_pkg::UNIT_HOUR) begin
        d = wrap_digit(int'(cal_hour), d, 0, cta_pkg::HOURS_IN_DAY, nxt);
        cal_hour = 5'(nxt);
        go = (d != 0);
      end
      if (go && r.unit <= cta_pkg::UNIT_DAY) begin
        d = wrap_digit(int'(cal_day), d, 1, cta_pkg::DAYS_IN_MONTH, nxt);
        cal_day = 5'(nxt);
        go = (d != 0);
      end
      if (go) begin
        // reaching the month repairs the season
        d = wrap_digit(int'(cal_month), d, 1, cta_pkg::MONTHS_IN_YEAR, nxt);
        cal_month  = 4'(nxt);
        cal_season = 3'((int'(cal_month) - 1) / 3 + 1);
        ovf = bump_year(d);
      end
    end
    t.year          = cal_year;
    t.season        = cal_season;
    t.month         = cal_month;
    t.day           = cal_day;
    t.hour          = cal_hour;
    t.minute        = cal_min;
    t.second        = cal_sec;
    t.year_overflow = ovf;
    return t;
  endfunction

  // a whole time, for rows whose result is plain to see
  function automatic cta_pkg::cta_rsp_t at(input int y, input int s, input int mo,
                                           input int d, input int h, input int mi,
                                           input int se, input int o);
    cta_pkg::cta_rsp_t t;
    t.year          = 16'(y);
    t.season        = 3'(s);
    t.month         = 4'(mo);
    t.day           = 5'(d);
    t.hour          = 5'(h);
    t.minute        = 6'(mi);
    t.second        = 6'(se);
    t.year_overflow = 1'(o);
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // expected times and mismatch bookkeeping
  // ---------------------------------------------------------------------
  cta_pkg::cta_rsp_t pending_times[$];
  cta_pkg::cta_rsp_t arrived_want;
  int                mismatches;
  int                times_checked;
  int                requests_sent;
  int                year_wraps;
  int                spare_units;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch %0d: %s", $realtime, mismatches, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                times_checked, name, got, want));
  endtask

  // result side: compare every accepted time with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_times.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  times_checked));
      end else begin
        arrived_want = pending_times.pop_front();
        check_field("year", int'(result.year), int'(arrived_want.year));
        check_field("season", int'(result.season), int'(arrived_want.season));
        check_field("month", int'(result.month), int'(arrived_want.month));
        check_field("day", int'(result.day), int'(arrived_want.day));
        check_field("hour", int'(result.hour), int'(arrived_want.hour));
        check_field("minute", int'(result.minute), int'(arrived_want.minute));
        check_field("second", int'(result.second), int'(arrived_want.second));
        check_field("year_overflow", int'(result.year_overflow),
                    int'(arrived_want.year_overflow));
      end
      times_checked++;
    end
  end

  // watchdog: too long without any handshake ends the run
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: stall patterns of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------
  int         hold_asked;
  int         hold_served;
  int         stall_left;
  int         stall_mode;
  logic [7:0] stall_mask;
  logic [2:0] stall_phase;

  initial begin
    result_stall = 1'b0;
    stall_left   = 0;
    stall_mode   = 0;
    stall_mask   = '0;
    stall_phase  = '0;
    hold_served  = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        // long hold-off so the block backs up into its request side
        result_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_served++;
      end else begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(20, 150);
          stall_mode = $urandom_range(0, 3);
          stall_mask = 8'($urandom);
        end
        stall_left--;
        case (stall_mode)
          0:       result_stall = 1'b0;
          1:       result_stall = ($urandom_range(0, 3) == 0);
          2:       result_stall = ($urandom_range(0, 3) != 0);
          default: result_stall = stall_mask[stall_phase];
        endcase
        stall_phase = stall_phase + 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------
  typedef struct {
    logic               cmd;
    logic [2:0]         unit;
    logic signed [15:0] amt;
    bit                 typed;
    cta_pkg::cta_rsp_t  want;
  } plan_row_t;

  localparam int PLAN_N = 27;

  plan_row_t plan [PLAN_N];
  int        burst_left;

  // offer one request, hold it until taken, then log what it should give
  task automatic offer(input cta_pkg::cta_req_t r, input bit typed,
                       input cta_pkg::cta_rsp_t want);
    cta_pkg::cta_rsp_t predicted;
    request_valid = 1'b1;
    request       = r;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    predicted = calendar_step(r);
    pending_times.push_back(typed ? want : predicted);
    requests_sent++;
    if (predicted.year_overflow) year_wraps++;
    if (r.unit == UNIT_SPARE) spare_units++;
    @(negedge clk);
  endtask

  // bursts of random length with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        request_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic cta_pkg::cta_req_t random_request();
    cta_pkg::cta_req_t r;
    int                pick;
    r.command = ($urandom_range(0, 9) < 3) ? cta_pkg::CMD_SET : cta_pkg::CMD_ADD;
    pick      = $urandom_range(0, 20);
    r.unit    = (pick == 20) ? UNIT_SPARE : 3'(pick % 7);
    pick      = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: r.amount = 16'(int'($urandom_range(0, 120)) - 60);
      4, 5:       r.amount = 16'(int'($urandom_range(0, 8000)) - 4000);
      6, 7:       r.amount = 16'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0:       r.amount = AMT_MAX;
          1:       r.amount = AMT_MIN;
          2:       r.amount = '1;
          default: r.amount = '0;
        endcase
      end
      // around the set ranges, just over and under their edges
      default:    r.amount = 16'(int'($urandom_range(0, 66)) - 3);
    endcase
    // now and then park the year close to a wrap
    if ($urandom_range(0, 39) == 0) begin
      r.command = cta_pkg::CMD_SET;
      r.unit    = cta_pkg::UNIT_YEAR;
      r.amount  = $urandom_range(0, 1) ? 16'(32767 - int'($urandom_range(0, 40)))
                                       : 16'(-32768 + int'($urandom_range(0, 40)));
    end
    return r;
  endfunction

  cta_pkg::cta_req_t next_req;

  initial begin
    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    hold_asked    = 0;
    burst_left    = 0;
    mismatches    = 0;
    times_checked = 0;
    requests_sent = 0;
    year_wraps    = 0;
    spare_units   = 0;
    cal_year      = '0;
    cal_season    = 3'd1;
    cal_month     = 4'd1;
    cal_day       = 5'd1;
    cal_hour      = 5'd6;
    cal_min       = '0;
    cal_sec       = '0;

    // directed rows; the first ones walk from the reset time to both wraps
    plan = '{
      // reset time comes back untouched by a zero add
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_SECOND, 16'sd0, 1'b1,
        at(0, 1, 1, 1, 6, 0, 0, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_YEAR, AMT_MAX, 1'b1,
        at(32767, 1, 1, 1, 6, 0, 0, 0)},
      // year wraps both ways
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_YEAR, 16'sd1, 1'b1,
        at(-32768, 1, 1, 1, 6, 0, 0, 1)},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_YEAR, -16'sd1, 1'b1,
        at(32767, 1, 1, 1, 6, 0, 0, 1)},
      // clamped sets up to the last instant of the year
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_SECOND, AMT_MIN, 1'b1,
        at(32767, 1, 1, 1, 6, 0, 0, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_SECOND, AMT_MAX, 1'b1,
        at(32767, 1, 1, 1, 6, 0, 59, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_MINUTE, 16'sd59, 1'b1,
        at(32767, 1, 1, 1, 6, 59, 59, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_HOUR, 16'sd23, 1'b1,
        at(32767, 1, 1, 1, 23, 59, 59, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_DAY, AMT_MAX, 1'b1,
        at(32767, 1, 1, 30, 23, 59, 59, 0)},
      // month set leaves the season alone
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_MONTH, 16'sd12, 1'b1,
        at(32767, 1, 12, 30, 23, 59, 59, 0)},
      // one second ripples through everything and wraps the year
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_SECOND, 16'sd1, 1'b1,
        at(-32768, 1, 1, 1, 0, 0, 0, 1)},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_SECOND, -16'sd1, 1'b1,
        at(32767, 4, 12, 30, 23, 59, 59, 1)},
      // spare unit code is ignored either way
      '{cta_pkg::CMD_ADD, UNIT_SPARE, 16'sd100, 1'b1,
        at(32767, 4, 12, 30, 23, 59, 59, 0)},
      '{cta_pkg::CMD_SET, UNIT_SPARE, -16'sd1, 1'b1,
        at(32767, 4, 12, 30, 23, 59, 59, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_SEASON, 16'sd0, 1'b1,
        at(32767, 1, 12, 30, 23, 59, 59, 0)},
      // zero month add still repairs the season
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_MONTH, 16'sd0, 1'b1,
        at(32767, 4, 12, 30, 23, 59, 59, 0)},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_SEASON, 16'sd9, 1'b0, NO_TIME},
      // season add carries into the year
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_SEASON, 16'sd1, 1'b0, NO_TIME},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_SEASON, AMT_MIN, 1'b0, NO_TIME},
      // carry stops at the second
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_SECOND, 16'sd0, 1'b0, NO_TIME},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_SECOND, 16'sd30, 1'b0, NO_TIME},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_HOUR, AMT_MIN, 1'b0, NO_TIME},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_DAY, 16'sd12345, 1'b0, NO_TIME},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_MONTH, AMT_MIN, 1'b0, NO_TIME},
      '{cta_pkg::CMD_ADD, cta_pkg::UNIT_YEAR, AMT_MAX, 1'b0, NO_TIME},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_YEAR, AMT_MIN, 1'b0, NO_TIME},
      '{cta_pkg::CMD_SET, cta_pkg::UNIT_DAY, 16'sd0, 1'b0, NO_TIME}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_N; i++) begin
      next_req.command = plan[i].cmd;
      next_req.unit    = plan[i].unit;
      next_req.amount  = plan[i].amt;
      offer(next_req, plan[i].typed, plan[i].want);
      pace();
    end

    for (int i = 0; i < RANDOM_N; i++) begin
      // receiver goes quiet while requests keep coming
      if (i == 250) hold_asked++;
      // sender waits for the block to drain completely
      if (i == 700) begin
        request_valid = 1'b0;
        while (pending_times.size() != 0) @(negedge clk);
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
      offer(random_request(), 1'b0, NO_TIME);
      pace();
    end
    request_valid = 1'b0;

    // drain, then give a stray result time to show up
    while (pending_times.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (pending_times.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_times.size()));

    $display("run: %0d requests (%0d directed, %0d spare unit), %0d results checked",
             requests_sent, PLAN_N, spare_units, times_checked);
    $display("run: %0d year wraps, one long receiver hold-off, one full drain",
             year_wraps);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cta_pkg.sv
sv/cta_digit_cell.sv
sv/cta_year_cell.sv
sv/calendar_time_adder.sv
dv/tb_calendar_time_adder.sv
